// ----- hdl/lgge_pkg.sv -----
// Shared types and constants of the life grid generation engine.
package lgge_pkg;

  // Defaults for the plane size.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Size registers
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 7'd64;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 7'd64;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Field widths of one beat
  localparam int OP_W    = 2;
  localparam int COORD_W = 6;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Three-by-three window around one cell: bit 0 west, bit 1 centre, bit 2 east
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } nbhd_t;

endpackage

// ----- hdl/life_grid_generation_engine.sv -----
// Top level of the life grid generation engine: plane memory, sequencer and ports.
//
//   channel   dir   beat contents
//   in_*      in    tuser: op; tdata: cell_x, cell_y, cell_value
//   out_*     out   tuser: done_op; tdata: read_value
//   cfg_*     in    index 0 grid_width, 1 grid_height, one write per enabled cycle
//
// From acceptance: a write or read goes through S_RWA and S_RWB, or outside the region
// straight to S_DONE; a clear zeroes all rows; a step does one cell per cycle, writes each
// row back, then zeroes the rows below. After reset a zeroing sweep runs with in_tready low.
// A finished result sits in the output register; the next beat is taken meanwhile,
// but a further result waits until out_tready frees that register.
module life_grid_generation_engine
  import lgge_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: cell_x [5:0], cell_y [11:6], cell_value [12], zero fill [15:13]
  input  logic [15:0]      in_tdata,
  // in_tuser: op [1:0]
  input  logic [OP_W-1:0]  in_tuser,
  input  logic             in_tvalid,
  output logic             in_tready,
  // out_tdata: read_value [0], zero fill [7:1]
  output logic [7:0]       out_tdata,
  // out_tuser: done_op [1:0]
  output logic [OP_W-1:0]  out_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_wr_en,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CWX = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
  localparam int CWY = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RWA, S_RWB, S_LD0, S_LD1, S_LD2, S_LD3,
    S_CELL, S_ROW, S_ZERO, S_DONE
  } state_t;

  typedef logic [MAX_WIDTH-1:0] row_t;

  // Plane memory, one row of cells per entry
  row_t mem [MAX_HEIGHT];
  row_t mem_q_r;
  logic          mem_we;
  logic [YW-1:0] mem_wa;
  row_t          mem_wd;
  logic [YW-1:0] rd_addr;

  state_t        state_r, state_nxt;
  logic          init_r, init_nxt;
  op_t           op_r, op_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic          val_r, val_nxt;
  logic          rdv_r, rdv_nxt;
  row_t          up_r, up_nxt;
  row_t          mid_r, mid_nxt;
  row_t          dn_r, dn_nxt;
  row_t          row0_r, row0_nxt;
  row_t          nrow_r, nrow_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_rdv_r, out_rdv_nxt;
  op_t           out_op_r, out_op_nxt;
  logic [CFG_W-1:0] grid_width_r, grid_height_r;

  logic [CWX-1:0] used_w;
  logic [CWY-1:0] used_h;
  logic [XW-1:0]  w_m1;
  logic [YW-1:0]  h_m1;
  logic [COORD_W-1:0] in_x, in_y;
  logic           in_val;
  logic           in_grid;
  logic [XW-1:0]  xm, xp;
  logic           y_wrap;
  nbhd_t          win;
  logic           cell_next;
  row_t           rw_row;

  // Size in use: zero reads as one, large values saturate
  always_comb begin
    if (grid_width_r == '0) begin
      used_w = CWX'(1);
    end else if (CWX'(grid_width_r) > CWX'(MAX_WIDTH)) begin
      used_w = CWX'(MAX_WIDTH);
    end else begin
      used_w = CWX'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      used_h = CWY'(1);
    end else if (CWY'(grid_height_r) > CWY'(MAX_HEIGHT)) begin
      used_h = CWY'(MAX_HEIGHT);
    end else begin
      used_h = CWY'(grid_height_r);
    end
    w_m1 = XW'(used_w - CWX'(1));
    h_m1 = YW'(used_h - CWY'(1));
  end

  // Unpack the input beat
  assign in_x    = in_tdata[5:0];
  assign in_y    = in_tdata[11:6];
  assign in_val  = in_tdata[12];
  assign in_grid = (CWX'(in_x) < used_w) && (CWY'(in_y) < used_h);

  // Window around the current cell, wrapping at the edges in use
  assign xm = (x_r == '0) ? w_m1 : x_r - XW'(1);
  assign xp = (x_r == w_m1) ? '0 : x_r + XW'(1);
  assign win.up  = {up_r[xp],  up_r[x_r],  up_r[xm]};
  assign win.mid = {mid_r[xp], mid_r[x_r], mid_r[xm]};
  assign win.dn  = {dn_r[xp],  dn_r[x_r],  dn_r[xm]};

  lgge_rule u_rule (
    .win   (win),
    .alive (cell_next)
  );

  // Row two below wraps back to row zero, whose original copy is held
  assign y_wrap = ((YW + 1)'(y_r) + (YW + 1)'(2)) > (YW + 1)'(h_m1);

  // Patched row for a cell write
  always_comb begin
    rw_row       = mem_q_r;
    rw_row[x_r]  = val_r;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    val_nxt       = val_r;
    rdv_nxt       = rdv_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    dn_nxt        = dn_r;
    row0_nxt      = row0_r;
    nrow_nxt      = nrow_r;
    out_valid_nxt = out_valid_r;
    out_rdv_nxt   = out_rdv_r;
    out_op_nxt    = out_op_r;
    mem_we        = 1'b0;
    mem_wa        = y_r;
    mem_wd        = '0;
    rd_addr       = y_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = op_t'(in_tuser);
          x_nxt   = XW'(in_x);
          y_nxt   = YW'(in_y);
          val_nxt = in_val;
          rdv_nxt = 1'b0;
          case (op_t'(in_tuser))
            OP_WRITE, OP_READ: begin
              state_nxt = in_grid ? S_RWA : S_DONE;
            end
            OP_STEP: begin
              y_nxt     = '0;
              state_nxt = S_LD0;
            end
            default: begin
              y_nxt     = '0;
              state_nxt = S_ZERO;
            end
          endcase
        end
      end
      S_RWA: begin
        rd_addr   = y_r;
        state_nxt = S_RWB;
      end
      S_RWB: begin
        if (op_r == OP_WRITE) begin
          mem_we = 1'b1;
          mem_wa = y_r;
          mem_wd = rw_row;
        end else begin
          rdv_nxt = mem_q_r[x_r];
        end
        state_nxt = S_DONE;
      end
      // Load the rows above, at and below row zero
      S_LD0: begin
        rd_addr   = h_m1;
        state_nxt = S_LD1;
      end
      S_LD1: begin
        rd_addr   = '0;
        up_nxt    = mem_q_r;
        state_nxt = S_LD2;
      end
      S_LD2: begin
        rd_addr   = (h_m1 == '0) ? '0 : YW'(1);
        mid_nxt   = mem_q_r;
        row0_nxt  = mem_q_r;
        state_nxt = S_LD3;
      end
      S_LD3: begin
        rd_addr   = y_r + YW'(2);
        dn_nxt    = mem_q_r;
        x_nxt     = '0;
        nrow_nxt  = '0;
        state_nxt = S_CELL;
      end
      // One cell per cycle; prefetch the row two below meanwhile
      S_CELL: begin
        rd_addr        = y_r + YW'(2);
        nrow_nxt[x_r]  = cell_next;
        if (x_r == w_m1) begin
          state_nxt = S_ROW;
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      // Write the new row back and advance the window
      S_ROW: begin
        rd_addr = y_r + YW'(2);
        mem_we  = 1'b1;
        mem_wa  = y_r;
        mem_wd  = nrow_r;
        up_nxt  = mid_r;
        mid_nxt = dn_r;
        dn_nxt  = y_wrap ? row0_r : mem_q_r;
        x_nxt   = '0;
        nrow_nxt = '0;
        if (y_r == h_m1) begin
          if (h_m1 == YW'(MAX_HEIGHT - 1)) begin
            state_nxt = S_DONE;
          end else begin
            y_nxt     = y_r + YW'(1);
            state_nxt = S_ZERO;
          end
        end else begin
          y_nxt     = y_r + YW'(1);
          state_nxt = S_CELL;
        end
      end
      // Zero rows up to the last one of the plane
      S_ZERO: begin
        mem_we = 1'b1;
        mem_wa = y_r;
        mem_wd = '0;
        if (y_r == YW'(MAX_HEIGHT - 1)) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end
      // Hand the result to the output register when it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rdv_nxt   = rdv_r;
          out_op_nxt    = op_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, working rows and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_ZERO;
      init_r        <= 1'b1;
      y_r           <= '0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= GRID_WIDTH_RESET;
      grid_height_r <= GRID_HEIGHT_RESET;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
          REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    val_r     <= val_nxt;
    rdv_r     <= rdv_nxt;
    up_r      <= up_nxt;
    mid_r     <= mid_nxt;
    dn_r      <= dn_nxt;
    row0_r    <= row0_nxt;
    nrow_r    <= nrow_nxt;
    out_rdv_r <= out_rdv_nxt;
    out_op_r  <= out_op_nxt;
  end

  // Plane memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_rdv_r};
  assign out_tuser  = out_op_r;

endmodule

// ----- hdl/lgge_rule.sv -----
// Neighbour count and B3/S23 rule for one cell.
module lgge_rule
  import lgge_pkg::*;
(
  input  nbhd_t win,
  output logic  alive
);

  logic [3:0] count;

  // Sum the eight neighbours, leave the centre out
  always_comb begin
    count = 4'(win.up[0]) + 4'(win.up[1]) + 4'(win.up[2])
          + 4'(win.mid[0]) + 4'(win.mid[2])
          + 4'(win.dn[0]) + 4'(win.dn[1]) + 4'(win.dn[2]);
  end

  // Born on three, survive on two or three
  always_comb begin
    if (win.mid[1]) begin
      alive = (count == 4'd2) || (count == 4'd3);
    end else begin
      alive = (count == 4'd3);
    end
  end

endmodule

// ----- verif/lgge_check.sv -----
// Checker for the life grid generation engine: shadow plane, result prediction and compare.
module lgge_check
  import lgge_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: cell_x [5:0], cell_y [11:6], cell_value [12], zero fill [15:13]
  input  logic [15:0]      in_tdata,
  // in_tuser: op [1:0]
  input  logic [OP_W-1:0]  in_tuser,
  input  logic             in_tvalid,
  input  logic             in_tready,
  // out_tdata: read_value [0], zero fill [7:1]
  input  logic [7:0]       out_tdata,
  // out_tuser: done_op [1:0]
  input  logic [OP_W-1:0]  out_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_wr_en,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic read_value;
    op_t  done_op;
  } cell_result_t;

  logic             shadow_cells [MAX_HEIGHT][MAX_WIDTH];
  logic [CFG_W-1:0] cols_reg;
  logic [CFG_W-1:0] rows_reg;
  cell_result_t     awaited_results [$];
  cell_result_t     seen_result;
  cell_result_t     want_result;
  int               bad_count = 0;

  assign mismatches = bad_count;

  // Map a size register onto the span in use: zero acts as one, large values saturate
  function automatic int clamp_size(logic [CFG_W-1:0] r, int limit);
    if (r == '0) return 1;
    if (int'(r) > limit) return limit;
    return int'(r);
  endfunction

  function automatic void wipe_plane();
    for (int y = 0; y < MAX_HEIGHT; y++)
      for (int x = 0; x < MAX_WIDTH; x++)
        shadow_cells[y][x] = 1'b0;
  endfunction

  // One B3/S23 generation over the region in use, wrapping at its edges;
  // everything outside the region comes out dead
  function automatic void evolve_plane();
    logic fresh [MAX_HEIGHT][MAX_WIDTH];
    int   w;
    int   h;
    int   alive;
    int   ny;
    int   nx;
    w = clamp_size(cols_reg, MAX_WIDTH);
    h = clamp_size(rows_reg, MAX_HEIGHT);
    for (int y = 0; y < MAX_HEIGHT; y++)
      for (int x = 0; x < MAX_WIDTH; x++)
        fresh[y][x] = 1'b0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        alive = 0;
        for (int dy = 0; dy < 3; dy++) begin
          ny = (y + h + dy - 1) % h;
          for (int dx = 0; dx < 3; dx++) begin
            nx = (x + w + dx - 1) % w;
            alive += int'(shadow_cells[ny][nx]);
          end
        end
        alive -= int'(shadow_cells[y][x]);
        if (shadow_cells[y][x])
          fresh[y][x] = (alive == 2 || alive == 3);
        else
          fresh[y][x] = (alive == 3);
      end
    end
    shadow_cells = fresh;
  endfunction

  // Apply one accepted beat to the shadow plane and return the result it must produce
  function automatic cell_result_t apply_beat(op_t op, int x, int y, logic v);
    cell_result_t r;
    bit           in_region;
    in_region    = (x < clamp_size(cols_reg, MAX_WIDTH)) &&
                   (y < clamp_size(rows_reg, MAX_HEIGHT));
    r.read_value = 1'b0;
    r.done_op    = op;
    case (op)
      OP_WRITE: if (in_region) shadow_cells[y][x] = v;
      OP_READ:  if (in_region) r.read_value = shadow_cells[y][x];
      OP_STEP:  evolve_plane();
      default:  wipe_plane();
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_plane();
      cols_reg = GRID_WIDTH_RESET;
      rows_reg = GRID_HEIGHT_RESET;
      awaited_results.delete();
      pending <= 0;
    end else begin
      // Track size register writes
      if (cfg_wr_en) begin
        if (cfg_addr == REG_GRID_WIDTH)
          cols_reg = cfg_wdata;
        else
          rows_reg = cfg_wdata;
      end

      // Compare a result beat with the oldest awaited result
      if (out_tvalid && out_tready) begin
        seen_result.read_value = out_tdata[0];
        seen_result.done_op    = op_t'(out_tuser);
        if (awaited_results.size() == 0) begin
          if (bad_count < 10)
            $display("%0t: result beat with nothing awaited: read_value=%0b done_op=%0d",
                     $realtime, seen_result.read_value, out_tuser);
          bad_count++;
        end else begin
          want_result = awaited_results.pop_front();
          if (seen_result.read_value !== want_result.read_value ||
              seen_result.done_op !== want_result.done_op) begin
            if (bad_count < 10)
              $display("%0t: result mismatch: expected read_value=%0b done_op=%s, got read_value=%0b done_op=%0d",
                       $realtime, want_result.read_value, want_result.done_op.name(),
                       seen_result.read_value, out_tuser);
            bad_count++;
          end
        end
      end

      // Predict the result of an accepted input beat
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_beat(op_t'(in_tuser), int'(in_tdata[5:0]),
                                             int'(in_tdata[11:6]), in_tdata[12]));

      pending <= awaited_results.size();
    end
  end

endmodule

// ----- verif/tb_life_grid_generation_engine.sv -----
// Testbench top for the life grid generation engine: clock, reset, stimulus and verdict.
module tb_life_grid_generation_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import lgge_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 110;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic [15:0]      in_tdata   = '0;
  logic [OP_W-1:0]  in_tuser   = OP_WRITE;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       out_tdata;
  logic [OP_W-1:0]  out_tuser;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic             cfg_wr_en  = 1'b0;
  logic             cfg_addr   = REG_GRID_WIDTH;
  logic [CFG_W-1:0] cfg_wdata  = '0;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int ready_left   = 0;
  bit calm         = 1'b0;
  int use_w        = 64;
  int use_h        = 64;

  life_grid_generation_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  lgge_check chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: ready bursts and stalls (mostly short, now and then long), no stalls if calm
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (calm || !out_tready) begin
      out_tready <= 1'b1;
      ready_left <= calm ? 8 : $urandom_range(0, 20);
    end else begin
      out_tready <= 1'b0;
      ready_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(20, 80);
    end
  end

  // Watchdog: give up when no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int span(int r, int limit);
    if (r == 0) return 1;
    if (r > limit) return limit;
    return r;
  endfunction

  // Random size register value: mostly small grids, sometimes the extremes
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(65, 127);
    if (roll == 2) return 64;
    if (roll == 3) return $urandom_range(1, 2);
    return $urandom_range(3, 12);
  endfunction

  // Present one input beat after a random gap and hold it until accepted
  task automatic send_beat(op_t op, int x, int y, bit v);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60)
      gap = 0;
    else if (roll < 90)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(10, 60);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {3'b000, v, y[5:0], x[5:0]};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every awaited result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both size registers on consecutive cycles
  task automatic set_grid(int w, int h);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_GRID_WIDTH;
    cfg_wdata <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_addr  <= REG_GRID_HEIGHT;
    cfg_wdata <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    use_w = span(w, 64);
    use_h = span(h, 64);
  endtask

  initial begin
    int budget;
    int n;
    int roll;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // Hold off until the zeroing sweep after reset has finished
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // Full plane with a saturated width: corners and a blinker across the wrap
    set_grid(127, 64);
    send_beat(OP_WRITE, 0, 0, 1'b1);
    send_beat(OP_WRITE, 63, 63, 1'b1);
    send_beat(OP_READ, 0, 0, 1'b0);
    send_beat(OP_READ, 63, 63, 1'b1);
    send_beat(OP_READ, 63, 0, 1'b0);
    send_beat(OP_WRITE, 63, 63, 1'b0);
    send_beat(OP_READ, 63, 63, 1'b0);
    send_beat(OP_WRITE, 63, 10, 1'b1);
    send_beat(OP_WRITE, 0, 10, 1'b1);
    send_beat(OP_WRITE, 1, 10, 1'b1);
    send_beat(OP_STEP, 0, 0, 1'b0);
    send_beat(OP_READ, 0, 9, 1'b0);
    send_beat(OP_READ, 0, 11, 1'b1);
    send_beat(OP_READ, 63, 10, 1'b0);
    send_beat(OP_CLEAR, 63, 63, 1'b1);
    send_beat(OP_READ, 0, 0, 1'b0);

    // Zero width acts as one column: outside access, and a cell seeing itself via wrap
    settle();
    set_grid(0, 3);
    send_beat(OP_WRITE, 5, 1, 1'b1);
    send_beat(OP_READ, 5, 1, 1'b1);
    send_beat(OP_WRITE, 0, 1, 1'b1);
    send_beat(OP_STEP, 0, 0, 1'b0);
    send_beat(OP_READ, 0, 1, 1'b0);
    send_beat(OP_WRITE, 0, 63, 1'b1);

    // Two by two torus
    settle();
    set_grid(2, 2);
    send_beat(OP_WRITE, 1, 1, 1'b1);
    send_beat(OP_STEP, 0, 0, 1'b0);
    send_beat(OP_READ, 1, 1, 1'b0);

    // Random phases: seed a pattern, then evolve it and probe it, with some noise
    budget = RANDOM_ITEMS;
    while (budget > 0) begin
      settle();
      calm <= ($urandom_range(0, 3) == 0);
      set_grid(pick_size(), pick_size());
      n = $urandom_range(12, 24);
      if ($urandom_range(0, 1) == 1)
        send_beat(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(0, 99);
        if (i < n / 2 && roll < 85)
          send_beat(OP_WRITE, $urandom_range(0, use_w - 1), $urandom_range(0, use_h - 1),
                    $urandom_range(0, 9) < 7);
        else if (i >= n / 2 && roll < 30)
          send_beat(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 1));
        else if (i >= n / 2 && roll < 80)
          send_beat(OP_READ, $urandom_range(0, use_w - 1), $urandom_range(0, use_h - 1),
                    $urandom_range(0, 1));
        else if (i >= n / 2 && roll < 84)
          send_beat(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 1));
        else
          send_beat($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 1));
      end
      budget -= n;
    end

    // Drain, let the block settle, then give the verdict
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lgge_pkg.sv
hdl/lgge_rule.sv
hdl/life_grid_generation_engine.sv
verif/lgge_check.sv
verif/tb_life_grid_generation_engine.sv
